// File: sv/osd_pkg.sv
`default_nettype none

package osd_pkg;

   // Sizing of the stores and the text line.
   localparam int MAX_CHARS         = 20;
   localparam int GLYPH_COUNT       = 13;
   localparam int MAX_GLYPH_HEIGHT  = 48;
   localparam int MIN_GLYPH_HEIGHT  = 16;
   localparam int DIGIT_COUNT       = 10;
   localparam int GSTRIDE           = (MAX_GLYPH_HEIGHT * MAX_GLYPH_HEIGHT) / 2;
   localparam int GLYPH_DEPTH       = GLYPH_COUNT * GSTRIDE;

   // Fixed field widths.
   localparam int CMD_W   = 2;
   localparam int GNUM_W  = 4;
   localparam int GOFF_W  = 11;
   localparam int BYTE_W  = 8;
   localparam int CPOS_W  = 5;
   localparam int IDX_W   = 15;
   localparam int GH_W    = 6;
   localparam int CC_W    = 5;

   // Derived widths.
   localparam int GADDR_W  = $clog2(GLYPH_DEPTH);
   localparam int H_W      = $clog2(MAX_GLYPH_HEIGHT + 1);
   localparam int W_W      = $clog2(MAX_GLYPH_HEIGHT / 2 + 1);
   localparam int N_W      = $clog2(MAX_CHARS + 1);
   localparam int POS_W    = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
   localparam int Q1_W     = ($clog2(MAX_GLYPH_HEIGHT) > POS_W) ? $clog2(MAX_GLYPH_HEIGHT)
                                                               : POS_W;
   localparam int Q2_W     = POS_W;
   localparam int OFF_W    = $clog2(GSTRIDE);
   localparam int GSIZE_W  = $clog2(GSTRIDE + 1);
   localparam int ROWLEN_W = $clog2((MAX_GLYPH_HEIGHT / 2) * MAX_CHARS + 1);
   localparam int IMG_W    = $clog2(GSTRIDE * MAX_CHARS + 1);
   localparam int D1_W     = (GSIZE_W > ROWLEN_W) ? GSIZE_W : ROWLEN_W;
   localparam int CMP_W    = ((IDX_W > D1_W + Q1_W) ? IDX_W : D1_W + Q1_W) + 1;
   localparam int NSTG     = 1 + Q1_W + Q2_W;

   // Result queue.
   localparam int FIFO_DEPTH = 32;
   localparam int FPTR_W     = $clog2(FIFO_DEPTH);
   localparam int LVL_W      = $clog2(FIFO_DEPTH + 1);

   // Character codes of the glyphs, glyph numbers of the non-digit glyphs and the alpha mask.
   localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [BYTE_W-1:0] CHAR_DASH  = 8'h2D;
   localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CHAR_COLON = 8'h3A;
   localparam logic [GNUM_W-1:0] GLYPH_DASH  = 4'd10;
   localparam logic [GNUM_W-1:0] GLYPH_SPACE = 4'd11;
   localparam logic [GNUM_W-1:0] GLYPH_COLON = 4'd12;
   localparam logic [BYTE_W-1:0] ALPHA_MASK  = 8'hC0;

   typedef enum logic [CMD_W-1:0] {
      CMD_GLYPH_WR = 2'd0,
      CMD_TEXT_WR  = 2'd1,
      CMD_PIXEL_RD = 2'd2
   } osd_cmd_type;

   typedef enum logic [1:0] {
      REG_GLYPH_HEIGHT   = 2'd0,
      REG_ROTATE_MODE    = 2'd1,
      REG_ALPHA_OVERRIDE = 2'd2,
      REG_CHAR_COUNT     = 2'd3
   } osd_reg_type;

   typedef struct packed {
      logic                rotate;
      logic [BYTE_W-1:0]   alpha;
      logic [W_W-1:0]      w;
      logic [N_W-1:0]      n;
      logic [GSIZE_W-1:0]  gsize;
      logic [ROWLEN_W-1:0] rowlen;
      logic [IMG_W-1:0]    image;
   } osd_cfg_type;

   typedef struct packed {
      osd_cmd_type         cmd;
      logic [GNUM_W-1:0]   gnum;
      logic [GOFF_W-1:0]   goff;
      logic [BYTE_W-1:0]   gbyte;
      logic [CPOS_W-1:0]   cpos;
      logic [BYTE_W-1:0]   ccode;
      logic [IDX_W-1:0]    idx;
   } osd_req_type;

   typedef struct packed {
      logic                vld;
      osd_req_type         req;
      logic [IDX_W-1:0]    rem;
      logic [Q1_W-1:0]     q1;
      logic [Q2_W-1:0]     q2;
   } osd_item_type;

   typedef struct packed {
      logic                vld;
      osd_req_type         req;
      logic [POS_W-1:0]    pos;
      logic [OFF_W-1:0]    off;
      logic                oob;
   } osd_addr_type;

   typedef struct packed {
      logic                ok;
      logic [GNUM_W-1:0]   num;
   } osd_gmap_type;

   typedef struct packed {
      logic                index_out_of_range;
      logic                bad_char;
      logic [BYTE_W-1:0]   alpha;
      logic [BYTE_W-1:0]   blue;
      logic [BYTE_W-1:0]   green;
      logic [BYTE_W-1:0]   red;
   } osd_rsp_type;

   function automatic osd_gmap_type glyph_of(input logic [BYTE_W-1:0] code);
      osd_gmap_type m;
      m.ok  = 1'b1;
      m.num = '0;
      if (code == CHAR_DASH) begin
         m.num = GLYPH_DASH;
      end else if (code == CHAR_SPACE) begin
         m.num = GLYPH_SPACE;
      end else if (code == CHAR_COLON) begin
         m.num = GLYPH_COLON;
      end else if (code >= CHAR_ZERO &&
                   int'(code) <= int'(CHAR_ZERO) + DIGIT_COUNT - 1) begin
         m.num = GNUM_W'(code - CHAR_ZERO);
      end else begin
         m.ok = 1'b0;
      end
      return m;
   endfunction

endpackage

`default_nettype wire

// File: sv/osd_glyph_text_rasterizer_unit.sv
`default_nettype none

// Channel   Direction  Handshake          Payload
// req       in         req_tvalid/tready  req_tdata: command, glyph_number, glyph_offset,
//                                         glyph_byte, char_position, char_code, pixel_index
// rsp       out        rsp_tvalid/tready  rsp_tdata: red, green, blue, alpha
//                                         rsp_tuser: bad_char, index_out_of_range
// csr       in         csr_we             csr_index, csr_wdata
//
// One item is taken every cycle while req_tready is high; a pixel read is written into the
// result queue after an input register, eleven division stages that each retire one quotient
// bit (six for the first division, five for the second), an address register and a register
// at each store, and can leave at the following edge. Reset clears the pipeline valids, the
// queue and the registers; the stores need no pass. Outside reset, req_tready drops only when
// the 32-entry result queue could not hold every read in flight.

module osd_glyph_text_rasterizer_unit (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   // command[1:0], glyph_number[5:2], glyph_offset[16:6], glyph_byte[24:17],
   // char_position[29:25], char_code[37:30], pixel_index[52:38], zero fill
   input  wire [55:0]  req_tdata,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // red[7:0], green[15:8], blue[23:16], alpha[31:24]
   output logic [31:0] rsp_tdata,
   // bad_char[0], index_out_of_range[1]
   output logic [1:0]  rsp_tuser,
   input  wire         csr_we,
   input  wire [1:0]   csr_index,
   input  wire [7:0]   csr_wdata
);

   logic [osd_pkg::GH_W-1:0]     glyph_height_ff;
   logic                         rotate_mode_ff;
   logic [osd_pkg::BYTE_W-1:0]   alpha_override_ff;
   logic [osd_pkg::CC_W-1:0]     char_count_ff;

   logic [osd_pkg::H_W-1:0]      h_cl;
   logic [osd_pkg::W_W-1:0]      w_cl;
   logic [osd_pkg::N_W-1:0]      n_cl;
   logic [osd_pkg::W_W-1:0]      w_ff;
   logic [osd_pkg::N_W-1:0]      n_ff;
   logic [osd_pkg::GSIZE_W-1:0]  gsize_ff;
   logic [osd_pkg::ROWLEN_W-1:0] rowlen_ff;
   logic [osd_pkg::IMG_W-1:0]    image_ff;
   osd_pkg::osd_cfg_type         cfg;

   osd_pkg::osd_req_type         req;
   osd_pkg::osd_addr_type        addr;
   osd_pkg::osd_addr_type        text_item;
   logic [osd_pkg::BYTE_W-1:0]   text_code;
   logic                         push;
   osd_pkg::osd_rsp_type         push_rsp;
   osd_pkg::osd_rsp_type         out_rsp;
   logic [osd_pkg::LVL_W-1:0]    level;
   logic [osd_pkg::LVL_W-1:0]    inflight_ff;
   logic [osd_pkg::LVL_W:0]      credit_sum;
   logic                         accept_rd;

   always_ff @(posedge clock) begin
      if (reset) begin
         glyph_height_ff   <= osd_pkg::GH_W'(osd_pkg::MIN_GLYPH_HEIGHT);
         rotate_mode_ff    <= 1'b0;
         alpha_override_ff <= '0;
         char_count_ff     <= osd_pkg::CC_W'(19);
      end else if (csr_we) begin
         unique case (osd_pkg::osd_reg_type'(csr_index))
            osd_pkg::REG_GLYPH_HEIGHT:   glyph_height_ff   <= csr_wdata[osd_pkg::GH_W-1:0];
            osd_pkg::REG_ROTATE_MODE:    rotate_mode_ff    <= csr_wdata[0];
            osd_pkg::REG_ALPHA_OVERRIDE: alpha_override_ff <= csr_wdata;
            osd_pkg::REG_CHAR_COUNT:     char_count_ff     <= csr_wdata[osd_pkg::CC_W-1:0];
            default:                     rotate_mode_ff    <= rotate_mode_ff;
         endcase
      end
   end

   // Cell height is clamped and forced even, so the cell is always H by H/2.
   always_comb begin
      if (int'(glyph_height_ff) < osd_pkg::MIN_GLYPH_HEIGHT) begin
         h_cl = osd_pkg::H_W'(osd_pkg::MIN_GLYPH_HEIGHT);
      end else if (int'(glyph_height_ff) > osd_pkg::MAX_GLYPH_HEIGHT) begin
         h_cl = osd_pkg::H_W'(osd_pkg::MAX_GLYPH_HEIGHT);
      end else begin
         h_cl = osd_pkg::H_W'(glyph_height_ff);
      end
      h_cl[0] = 1'b0;
      w_cl = osd_pkg::W_W'(h_cl >> 1);
      if (int'(char_count_ff) > osd_pkg::MAX_CHARS) begin
         n_cl = osd_pkg::N_W'(osd_pkg::MAX_CHARS);
      end else begin
         n_cl = osd_pkg::N_W'(char_count_ff);
      end
   end

   // The image size is used at the end of the address pipeline, so it is registered from the registered glyph size.
   always_ff @(posedge clock) begin
      w_ff      <= w_cl;
      n_ff      <= n_cl;
      gsize_ff  <= osd_pkg::GSIZE_W'(h_cl) * osd_pkg::GSIZE_W'(w_cl);
      rowlen_ff <= osd_pkg::ROWLEN_W'(w_cl) * osd_pkg::ROWLEN_W'(n_cl);
      image_ff  <= osd_pkg::IMG_W'(gsize_ff) * osd_pkg::IMG_W'(n_ff);
   end

   assign cfg.rotate = rotate_mode_ff;
   assign cfg.alpha  = alpha_override_ff;
   assign cfg.w      = w_ff;
   assign cfg.n      = n_ff;
   assign cfg.gsize  = gsize_ff;
   assign cfg.rowlen = rowlen_ff;
   assign cfg.image  = image_ff;

   assign req.cmd   = osd_pkg::osd_cmd_type'(req_tdata[1:0]);
   assign req.gnum  = req_tdata[5:2];
   assign req.goff  = req_tdata[16:6];
   assign req.gbyte = req_tdata[24:17];
   assign req.cpos  = req_tdata[29:25];
   assign req.ccode = req_tdata[37:30];
   assign req.idx   = req_tdata[52:38];

   // Credit check: every read in flight has a queue entry waiting for it.
   assign credit_sum = {1'b0, level} + {1'b0, inflight_ff};
   assign req_tready = !reset && int'(credit_sum) < osd_pkg::FIFO_DEPTH;
   assign accept_rd  = req_tvalid && req_tready && req.cmd == osd_pkg::CMD_PIXEL_RD;

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         case ({accept_rd, push})
            2'b10:   inflight_ff <= inflight_ff + 1'b1;
            2'b01:   inflight_ff <= inflight_ff - 1'b1;
            default: inflight_ff <= inflight_ff;
         endcase
      end
   end

   osd_addr_pipe u_addr_pipe (
      .clock  (clock),
      .reset  (reset),
      .in_vld (req_tvalid && req_tready),
      .in_req (req),
      .cfg    (cfg),
      .addr   (addr)
   );

   osd_char_lookup u_char_lookup (
      .clock (clock),
      .reset (reset),
      .addr  (addr),
      .item  (text_item),
      .code  (text_code)
   );

   osd_glyph_fetch u_glyph_fetch (
      .clock (clock),
      .reset (reset),
      .item  (text_item),
      .code  (text_code),
      .cfg   (cfg),
      .push  (push),
      .rsp   (push_rsp)
   );

   osd_rsp_fifo u_rsp_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .din     (push_rsp),
      .out_vld (rsp_tvalid),
      .out_rdy (rsp_tready),
      .dout    (out_rsp),
      .level   (level)
   );

   assign rsp_tdata = {out_rsp.alpha, out_rsp.blue, out_rsp.green, out_rsp.red};
   assign rsp_tuser = {out_rsp.index_out_of_range, out_rsp.bad_char};

endmodule

`default_nettype wire

// File: sv/osd_addr_pipe.sv
`default_nettype none

module osd_addr_pipe (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  in_vld,
   input  osd_pkg::osd_req_type in_req,
   input  osd_pkg::osd_cfg_type cfg,
   output osd_pkg::osd_addr_type addr
);

   osd_pkg::osd_item_type st_ff [osd_pkg::NSTG];
   osd_pkg::osd_item_type st_in [osd_pkg::NSTG];
   logic [osd_pkg::CMP_W-1:0] trial [osd_pkg::NSTG-1];
   logic [osd_pkg::D1_W-1:0]  d1;
   osd_pkg::osd_addr_type     addr_ff;
   osd_pkg::osd_addr_type     addr_in;
   osd_pkg::osd_item_type     last;

   // Rotated layout divides by the glyph size, normal layout by the row length.
   assign d1 = cfg.rotate ? osd_pkg::D1_W'(cfg.gsize) : osd_pkg::D1_W'(cfg.rowlen);

   always_comb begin
      st_in[0].vld = in_vld;
      st_in[0].req = in_req;
      st_in[0].rem = in_req.idx;
      st_in[0].q1  = '0;
      st_in[0].q2  = '0;
      for (int i = 0; i < osd_pkg::NSTG - 1; i++) begin
         st_in[i+1] = st_ff[i];
         if (i < osd_pkg::Q1_W) begin
            trial[i] = osd_pkg::CMP_W'(d1) << (osd_pkg::Q1_W - 1 - i);
            if (osd_pkg::CMP_W'(st_ff[i].rem) >= trial[i]) begin
               st_in[i+1].rem = st_ff[i].rem - osd_pkg::IDX_W'(trial[i]);
               st_in[i+1].q1[osd_pkg::Q1_W-1-i] = 1'b1;
            end
         end else begin
            // Second division by the cell width splits the row into position and column.
            trial[i] = osd_pkg::CMP_W'(cfg.w) << (osd_pkg::Q1_W + osd_pkg::Q2_W - 1 - i);
            if (!cfg.rotate && osd_pkg::CMP_W'(st_ff[i].rem) >= trial[i]) begin
               st_in[i+1].rem = st_ff[i].rem - osd_pkg::IDX_W'(trial[i]);
               st_in[i+1].q2[osd_pkg::Q1_W+osd_pkg::Q2_W-1-i] = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < osd_pkg::NSTG; i++) begin
            st_ff[i].vld <= 1'b0;
         end
      end else begin
         st_ff <= st_in;
      end
   end

   assign last = st_ff[osd_pkg::NSTG-1];

   always_comb begin
      addr_in.vld = last.vld;
      addr_in.req = last.req;
      addr_in.oob = int'(last.req.idx) >= int'(cfg.image);
      if (cfg.rotate) begin
         addr_in.pos = osd_pkg::POS_W'(int'(cfg.n) - 1 - int'(last.q1));
         addr_in.off = osd_pkg::OFF_W'(last.rem);
      end else begin
         addr_in.pos = last.q2;
         addr_in.off = osd_pkg::OFF_W'(last.q1) * osd_pkg::OFF_W'(cfg.w)
                     + osd_pkg::OFF_W'(last.rem);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff.vld <= 1'b0;
      end else begin
         addr_ff <= addr_in;
      end
   end

   assign addr = addr_ff;

endmodule

`default_nettype wire

// File: sv/osd_char_lookup.sv
`default_nettype none

module osd_char_lookup (
   input  wire                         clock,
   input  wire                         reset,
   input  osd_pkg::osd_addr_type       addr,
   output osd_pkg::osd_addr_type       item,
   output logic [osd_pkg::BYTE_W-1:0]  code
);

   logic [osd_pkg::BYTE_W-1:0] text_mem [osd_pkg::MAX_CHARS];
   logic [osd_pkg::BYTE_W-1:0] code_ff;
   osd_pkg::osd_addr_type      item_ff;
   logic                       text_we;

   assign text_we = addr.vld && addr.req.cmd == osd_pkg::CMD_TEXT_WR &&
                    int'(addr.req.cpos) < osd_pkg::MAX_CHARS;

   // Items pass in order, so a read always sees every earlier text write.
   always_ff @(posedge clock) begin
      if (text_we) begin
         text_mem[osd_pkg::POS_W'(addr.req.cpos)] <= addr.req.ccode;
      end
      code_ff <= text_mem[addr.pos];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff.vld <= 1'b0;
      end else begin
         item_ff <= addr;
      end
   end

   assign item = item_ff;
   assign code = code_ff;

endmodule

`default_nettype wire

// File: sv/osd_glyph_fetch.sv
`default_nettype none

module osd_glyph_fetch (
   input  wire                         clock,
   input  wire                         reset,
   input  osd_pkg::osd_addr_type       item,
   input  wire [osd_pkg::BYTE_W-1:0]   code,
   input  osd_pkg::osd_cfg_type        cfg,
   output logic                        push,
   output osd_pkg::osd_rsp_type        rsp
);

   logic [osd_pkg::BYTE_W-1:0]  glyph_mem [osd_pkg::GLYPH_DEPTH];
   logic [osd_pkg::BYTE_W-1:0]  pat_ff;
   logic [osd_pkg::GADDR_W-1:0] raddr;
   logic [osd_pkg::GADDR_W-1:0] waddr;
   logic                        glyph_we;
   osd_pkg::osd_gmap_type       gmap;
   logic                        rd_vld_ff;
   logic                        oob_ff;
   logic                        bad_ff;

   assign gmap  = osd_pkg::glyph_of(code);
   assign raddr = osd_pkg::GADDR_W'(gmap.num) * osd_pkg::GADDR_W'(osd_pkg::GSTRIDE)
                + osd_pkg::GADDR_W'(item.off);
   assign waddr = osd_pkg::GADDR_W'(item.req.gnum) * osd_pkg::GADDR_W'(osd_pkg::GSTRIDE)
                + osd_pkg::GADDR_W'(item.req.goff);
   assign glyph_we = item.vld && item.req.cmd == osd_pkg::CMD_GLYPH_WR &&
                     int'(item.req.gnum) < osd_pkg::GLYPH_COUNT &&
                     int'(item.req.goff) < osd_pkg::GSTRIDE;

   always_ff @(posedge clock) begin
      if (glyph_we) begin
         glyph_mem[waddr] <= item.req.gbyte;
      end
      pat_ff <= glyph_mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= item.vld && item.req.cmd == osd_pkg::CMD_PIXEL_RD;
      end
      oob_ff <= item.oob;
      bad_ff <= !gmap.ok;
   end

   // An index beyond the image wins over a bad character.
   always_comb begin
      rsp = '0;
      if (oob_ff) begin
         rsp.index_out_of_range = 1'b1;
      end else if (bad_ff) begin
         rsp.bad_char = 1'b1;
      end else begin
         rsp.red   = {pat_ff[1:0], 6'b0};
         rsp.green = {pat_ff[3:2], 6'b0};
         rsp.blue  = {pat_ff[5:4], 6'b0};
         rsp.alpha = (cfg.alpha != '0) ? cfg.alpha : (pat_ff & osd_pkg::ALPHA_MASK);
      end
   end

   assign push = rd_vld_ff;

endmodule

`default_nettype wire

// File: sv/osd_rsp_fifo.sv
`default_nettype none

module osd_rsp_fifo (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         push,
   input  osd_pkg::osd_rsp_type        din,
   output logic                        out_vld,
   input  wire                         out_rdy,
   output osd_pkg::osd_rsp_type        dout,
   output logic [osd_pkg::LVL_W-1:0]   level
);

   osd_pkg::osd_rsp_type          fifo_mem [osd_pkg::FIFO_DEPTH];
   logic [osd_pkg::FPTR_W-1:0]    wr_ptr_ff;
   logic [osd_pkg::FPTR_W-1:0]    rd_ptr_ff;
   logic [osd_pkg::LVL_W-1:0]     level_ff;
   logic                          pop;

   assign out_vld = level_ff != '0;
   assign pop     = out_vld && out_rdy;
   assign dout    = fifo_mem[rd_ptr_ff];
   assign level   = level_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_mem[wr_ptr_ff] <= din;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         case ({push, pop})
            2'b10:   level_ff <= level_ff + 1'b1;
            2'b01:   level_ff <= level_ff - 1'b1;
            default: level_ff <= level_ff;
         endcase
      end
   end

endmodule

`default_nettype wire
